/* design/morph_vertex_blend_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the morph vertex blend block
// Short forms for clocked concurrent assertions. The surrounding scope must
// provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MORPH_VERTEX_BLEND_ASSERT_SVH
`define MORPH_VERTEX_BLEND_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MVB_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("morph_vertex_blend: property failed");

// A condition that must never be seen at a clock edge outside reset.
`define MVB_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("morph_vertex_blend: forbidden condition seen");

`endif

/* design/mvb_pkg.sv */
// ----------------------------------------------------------------------------
// mvb_pkg
// Types and constants shared by the morph vertex blend block.
// ----------------------------------------------------------------------------
package mvb_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int VTX_AW       = $clog2(VERTEX_DEPTH);

  localparam int COORD_W  = 32;
  localparam int INDEX_W  = 12;
  localparam int RATE_W   = 17;
  localparam int COUNT_W  = 13;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 2'd0,
    OP_SET  = 2'd1,
    OP_ADD  = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  localparam int VTX_W = $bits(vtx_t);

endpackage

/* design/morph_vertex_blend.sv */
// ----------------------------------------------------------------------------
// morph_vertex_blend
// Vertex position store with load, set, scaled-offset add and read-back.
// ----------------------------------------------------------------------------
//   channel  | handshake                 | words
//   ---------+---------------------------+--------------------------------
//   in       | start, busy               | opcode, index, x/y/z, rate
//   out      | out_valid (one-cycle)     | x/y/z, status
//   cfg      | cfg_we                    | vertex_count
//
// From acceptance to its result strobe an item passes through the position
// memory read, the three rate multipliers, and the add, clamp and write-back,
// in that order. The next word is accepted in the cycle in which the result
// is shown, so a new word is not taken before the last one is through.
// Reset clears the control state and the vertex count; the position memory
// is not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module morph_vertex_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mvb_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [mvb_pkg::INDEX_W-1:0]         in_vertex_index,
  input  logic signed [mvb_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [mvb_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [mvb_pkg::COORD_W-1:0]  in_coord_z,
  input  logic [mvb_pkg::RATE_W-1:0]          in_blend_rate,
  output logic                                out_valid,
  output logic signed [mvb_pkg::COORD_W-1:0]  out_x,
  output logic signed [mvb_pkg::COORD_W-1:0]  out_y,
  output logic signed [mvb_pkg::COORD_W-1:0]  out_z,
  output logic [mvb_pkg::STATUS_W-1:0]        out_status,
  input  logic                                cfg_we,
  input  logic [mvb_pkg::COUNT_W-1:0]         cfg_data
);

  import mvb_pkg::*;

  localparam int PROD_W  = COORD_W + RATE_W + 1;
  localparam int SCALE_W = PROD_W - 16;
  localparam int SUM_W   = SCALE_W + 1;

  typedef struct packed {
    logic               sat;
    logic [COORD_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_add(input logic signed [COORD_W-1:0] base,
                                       input logic signed [SCALE_W-1:0] ofs);
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-COORD_W:0]  top;
    clamp_t                  r;
    s   = SUM_W'(base) + SUM_W'(ofs);
    top = s[SUM_W-1:COORD_W-1];
    // The sum fits when all bits above the 32-bit sign bit agree with it.
    if (top == '0 || top == '1) begin
      r.sat = 1'b0;
      r.val = s[COORD_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = s[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_t                    state_r, state_nxt;
  logic [COUNT_W-1:0]        vcount_r;
  opcode_t                   op_r;
  logic [VTX_AW-1:0]         addr_r;
  logic                      inrange_r;
  vtx_t                      coord_r;
  logic [RATE_W-1:0]         rate_r;
  logic signed [SCALE_W-1:0] scl_x_r, scl_y_r, scl_z_r;
  logic                      out_valid_r;
  vtx_t                      out_pos_r;
  status_t                   out_status_r;

  logic                      accept;
  logic                      in_range;
  logic                      ram_re;
  logic                      ram_we;
  logic                      out_load;
  logic                      mul_load;
  vtx_t                      ram_rdata;
  vtx_t                      result;
  status_t                   result_status;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  clamp_t                    cx, cy, cz;

  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_vertex_index} < vcount_r) &&
                    (32'(in_vertex_index) < VERTEX_DEPTH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    busy     = 1'b1;
    ram_re   = 1'b0;
    mul_load = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        ram_re = start;
      end
      S_MUL:   mul_load = 1'b1;
      S_ADD:   out_load = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load;
      if (cfg_we) begin
        vcount_r <= cfg_data;
      end
    end
  end

  // Captured input word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= opcode_t'(in_opcode);
      addr_r    <= VTX_AW'(in_vertex_index);
      inrange_r <= in_range;
      coord_r   <= '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
      rate_r    <= in_blend_rate;
    end
  end

  mvb_ram #(
    .WIDTH (VTX_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (result),
    .re    (ram_re),
    .raddr (VTX_AW'(in_vertex_index)),
    .rdata (ram_rdata)
  );

  // Offset times rate; the arithmetic shift drops the low bits toward minus
  // infinity.
  assign prod_x = coord_r.x * $signed({1'b0, rate_r});
  assign prod_y = coord_r.y * $signed({1'b0, rate_r});
  assign prod_z = coord_r.z * $signed({1'b0, rate_r});

  always_ff @(posedge clk) begin
    if (mul_load) begin
      scl_x_r <= prod_x[PROD_W-1:16];
      scl_y_r <= prod_y[PROD_W-1:16];
      scl_z_r <= prod_z[PROD_W-1:16];
    end
  end

  assign cx = clamp_add(ram_rdata.x, scl_x_r);
  assign cy = clamp_add(ram_rdata.y, scl_y_r);
  assign cz = clamp_add(ram_rdata.z, scl_z_r);

  always_comb begin
    result        = ram_rdata;
    result_status = ST_OK;
    case (op_r)
      OP_LOAD, OP_SET: result = coord_r;
      OP_ADD: begin
        result = '{x: cx.val, y: cy.val, z: cz.val};
        if (cx.sat || cy.sat || cz.sat) begin
          result_status = ST_SAT;
        end
      end
      OP_READ: result = ram_rdata;
      default: result = ram_rdata;
    endcase
  end

  assign ram_we = out_load && inrange_r && (op_r != OP_READ);

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (inrange_r) begin
        out_pos_r    <= result;
        out_status_r <= result_status;
      end else begin
        out_pos_r    <= '0;
        out_status_r <= ST_RANGE;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_pos_r.x;
  assign out_y      = out_pos_r.y;
  assign out_z      = out_pos_r.z;
  assign out_status = out_status_r;

endmodule

/* design/mvb_ram.sv */
// ----------------------------------------------------------------------------
// mvb_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module mvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/mvb_checker.sv */
// ----------------------------------------------------------------------------
// mvb_checker
// Port-level checks on the morph vertex blend block, bound to the top level.
// ----------------------------------------------------------------------------
`include "morph_vertex_blend_assert.svh"

module mvb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [mvb_pkg::COORD_W-1:0]  out_x,
  input logic signed [mvb_pkg::COORD_W-1:0]  out_y,
  input logic signed [mvb_pkg::COORD_W-1:0]  out_z,
  input logic [mvb_pkg::STATUS_W-1:0]        out_status
);

  import mvb_pkg::*;

  // Every accepted word is followed by its result strobe.
  `MVB_ASSERT_PROP(a_result_latency, (start && !busy) |-> ##3 out_valid)

  // The strobe lasts a single cycle.
  `MVB_ASSERT_PROP(a_strobe_single, out_valid |=> !out_valid)

  // The block is free again while a result is shown.
  `MVB_ASSERT_NEVER(a_busy_on_result, out_valid && busy)

  // A rejected index reports a zero position.
  `MVB_ASSERT_NEVER(a_range_zero,
    out_valid && out_status == ST_RANGE && (out_x != 0 || out_y != 0 || out_z != 0))

  // No status code beyond the defined ones.
  `MVB_ASSERT_NEVER(a_status_code,
    out_valid && out_status != ST_OK && out_status != ST_RANGE && out_status != ST_SAT)

endmodule

bind morph_vertex_blend mvb_checker u_mvb_checker (.*);
